>>> rtl/core/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants of the two-fan PWM ramp and tachometer block.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int ACTION_W   = 3;
    localparam int DUTY_W     = 8;
    localparam int EDGE_W     = 2;
    localparam int FAN_W      = 1;
    localparam int RPM_W      = 16;
    localparam int MS_W       = 16;
    localparam int NUMER_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_FANS   = 2;

    typedef logic [ACTION_W-1:0]   action_t;
    typedef logic [DUTY_W-1:0]     duty_t;
    typedef logic [EDGE_W-1:0]     edge_mask_t;
    typedef logic [FAN_W-1:0]      fan_sel_t;
    typedef logic [RPM_W-1:0]      rpm_t;
    typedef logic [MS_W-1:0]       ms_t;
    typedef logic [NUMER_W-1:0]    numer_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam action_t ACT_SET_CONTROL  = 3'd0;
    localparam action_t ACT_SET_OVERRIDE = 3'd1;
    localparam action_t ACT_MS_TICK      = 3'd2;
    localparam action_t ACT_REF_TICK     = 3'd3;
    localparam action_t ACT_RPM_QUERY    = 3'd4;

    localparam cfg_idx_t REG_RAMP_INTERVAL = 2'd0;
    localparam cfg_idx_t REG_NO_SPIN       = 2'd1;
    localparam cfg_idx_t REG_RPM_NUMER     = 2'd2;

    localparam ms_t    RAMP_INTERVAL_RST = 16'd10;
    localparam ms_t    NO_SPIN_RST       = 16'd1000;
    localparam numer_t RPM_NUMER_RST     = 32'd300000;
    localparam ms_t    MS_SAT            = 16'hffff;
    localparam rpm_t   RPM_SAT           = 16'hffff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_REPLY
    } fpr_state_t;

    // Tick controls handed from the sequencer to the tachometer counters.
    typedef struct packed {
        logic       ms_tick;
        logic       ref_tick;
        edge_mask_t edge_mask;
    } tach_ctrl_t;

endpackage

>>> rtl/core/fpr_item_if.sv
// ----------------------------------------------------------------------------
// fpr_item_if
// Input item channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface fpr_item_if;
    import fpr_pkg::*;

    logic       valid;
    logic       ready;
    action_t    action;
    duty_t      duty_value;
    edge_mask_t edge_mask;
    fan_sel_t   fan_select;

    modport source (output valid, output action, output duty_value, output edge_mask,
                    output fan_select, input ready);
    modport sink   (input valid, input action, input duty_value, input edge_mask,
                    input fan_select, output ready);
endinterface

>>> rtl/core/fpr_result_if.sv
// ----------------------------------------------------------------------------
// fpr_result_if
// Result channel: valid/ready handshake with duty and speed readings.
// ----------------------------------------------------------------------------
interface fpr_result_if;
    import fpr_pkg::*;

    logic  valid;
    logic  ready;
    duty_t current_duty;
    duty_t target_duty;
    rpm_t  fan_rpm;

    modport source (output valid, output current_duty, output target_duty, output fan_rpm,
                    input ready);
    modport sink   (input valid, input current_duty, input target_duty, input fan_rpm,
                    output ready);
endinterface

>>> rtl/core/fpr_cfg_if.sv
// ----------------------------------------------------------------------------
// fpr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fpr_cfg_if;
    import fpr_pkg::*;

    logic      valid;
    logic      ready;
    cfg_idx_t  index;
    cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/fpr_divider.sv
// ----------------------------------------------------------------------------
// fpr_divider
// Restoring divider, one quotient bit per cycle, with a saturated rpm result.
// ----------------------------------------------------------------------------
module fpr_divider #(
    parameter int PERIOD_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  fpr_pkg::numer_t        dividend,
    input  logic [PERIOD_BITS-1:0] divisor,
    output logic                   done,
    output fpr_pkg::rpm_t          quotient
);
    import fpr_pkg::*;

    localparam int CNT_W = $clog2(NUMER_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUMER_W - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PERIOD_BITS-1:0] rem_reg, rem_next;
    logic [PERIOD_BITS-1:0] div_reg;
    numer_t                 quo_reg, quo_next;

    logic [PERIOD_BITS:0]   shifted;
    logic [PERIOD_BITS+1:0] trial;
    logic                   borrow;

    // The dividend shifts out of the top of quo_reg while quotient bits enter below.
    assign shifted = {rem_reg, quo_reg[NUMER_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};
    assign borrow  = trial[PERIOD_BITS+1];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            quo_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next   = borrow ? shifted[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
            quo_next   = {quo_reg[NUMER_W-2:0], ~borrow};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[NUMER_W-1:RPM_W] != '0) ? RPM_SAT : quo_reg[RPM_W-1:0];

endmodule

>>> rtl/core/fpr_tach.sv
// ----------------------------------------------------------------------------
// fpr_tach
// Per-fan period counters, latched periods and time since the last tach edge.
// ----------------------------------------------------------------------------
module fpr_tach #(
    parameter int PERIOD_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fpr_pkg::tach_ctrl_t    ctrl,
    input  fpr_pkg::fan_sel_t      fan_select,
    output logic [PERIOD_BITS-1:0] period_sel,
    output fpr_pkg::ms_t           ms_sel
);
    import fpr_pkg::*;

    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

    logic [PERIOD_BITS-1:0] running_reg [NUM_FANS];
    logic [PERIOD_BITS-1:0] latched_reg [NUM_FANS];
    ms_t                    since_reg   [NUM_FANS];

    for (genvar i = 0; i < NUM_FANS; i++)
    begin : g_fan
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                running_reg[i] <= '0;
                latched_reg[i] <= '0;
                since_reg[i]   <= '0;
            end
            else if (ctrl.ref_tick)
            begin
                if (ctrl.edge_mask[i])
                begin
                    latched_reg[i] <= running_reg[i];
                    running_reg[i] <= '0;
                    since_reg[i]   <= '0;
                end
                else if (running_reg[i] != PERIOD_MAX)
                begin
                    running_reg[i] <= running_reg[i] + 1'b1;
                end
            end
            else if (ctrl.ms_tick && since_reg[i] != MS_SAT)
            begin
                since_reg[i] <= since_reg[i] + 1'b1;
            end
        end
    end

    assign period_sel = latched_reg[fan_select];
    assign ms_sel     = since_reg[fan_select];

endmodule

>>> rtl/core/fan_pwm_ramp_and_tach_rpm.sv
// ----------------------------------------------------------------------------
// fan_pwm_ramp_and_tach_rpm
// Two-fan PWM duty ramp controller with tachometer speed measurement.
// ----------------------------------------------------------------------------
// Every transaction on item_in yields exactly one transaction on result_out.
// Duty settings, millisecond ticks and reference ticks complete in the cycle
// they are accepted, and their result is registered straight away; the next
// transaction is accepted as soon as the result register is free. An rpm query
// for a running fan waits in ST_DIVIDE and then ST_REPLY before a valid result: the
// quotient comes from a restoring divider that produces one bit of the 32-bit
// numerator per cycle, and item_in stays not ready until that result has been
// registered. A query on a stalled fan or a zero period answers at once.
// Configuration writes are always taken and act immediately.
// ----------------------------------------------------------------------------
module fan_pwm_ramp_and_tach_rpm #(
    parameter int PERIOD_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    fpr_item_if.sink     item_in,
    fpr_result_if.source result_out,
    fpr_cfg_if.sink      cfg
);
    import fpr_pkg::*;

    fpr_state_t state_reg, state_next;

    ms_t    ramp_interval_reg;
    ms_t    no_spin_reg;
    numer_t rpm_numer_reg;

    duty_t control_reg,  control_next;
    duty_t override_reg, override_next;
    duty_t driven_reg,   driven_next;
    ms_t   ramp_wait_reg, ramp_wait_next;

    logic  out_valid_reg, out_valid_next;
    duty_t out_current_reg, out_current_next;
    duty_t out_target_reg,  out_target_next;
    rpm_t  out_rpm_reg,     out_rpm_next;
    rpm_t  quot_reg,        quot_next;

    logic                   accept;
    logic                   slot_free;
    logic                   div_start;
    logic                   div_done;
    rpm_t                   div_quot;
    tach_ctrl_t             tach_ctrl;
    logic [PERIOD_BITS-1:0] period_sel;
    ms_t                    ms_sel;
    duty_t                  target_cur;
    duty_t                  target_next;
    ms_t                    wait_dec;
    logic                   stalled;

    assign slot_free     = !out_valid_reg || result_out.ready;
    assign item_in.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept        = item_in.valid && item_in.ready;
    assign cfg.ready     = 1'b1;

    assign tach_ctrl.ms_tick   = accept && (item_in.action == ACT_MS_TICK);
    assign tach_ctrl.ref_tick  = accept && (item_in.action == ACT_REF_TICK);
    assign tach_ctrl.edge_mask = item_in.edge_mask;

    fpr_tach #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_tach (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (tach_ctrl),
        .fan_select (item_in.fan_select),
        .period_sel (period_sel),
        .ms_sel     (ms_sel)
    );

    fpr_divider #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rpm_numer_reg),
        .divisor  (period_sel),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign target_cur = (override_reg > control_reg) ? override_reg : control_reg;
    assign wait_dec   = (ramp_wait_reg != '0) ? ramp_wait_reg - 1'b1 : ramp_wait_reg;
    assign stalled    = (period_sel == '0) || (ms_sel > no_spin_reg);

    always_comb
    begin
        state_next       = state_reg;
        control_next     = control_reg;
        override_next    = override_reg;
        driven_next      = driven_reg;
        ramp_wait_next   = ramp_wait_reg;
        quot_next        = quot_reg;
        div_start        = 1'b0;
        out_valid_next   = out_valid_reg && !result_out.ready;
        out_current_next = out_current_reg;
        out_target_next  = out_target_reg;
        out_rpm_next     = out_rpm_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item_in.action)
                        ACT_SET_CONTROL:  control_next  = item_in.duty_value;
                        ACT_SET_OVERRIDE: override_next = item_in.duty_value;
                        ACT_MS_TICK:
                        begin
                            ramp_wait_next = wait_dec;
                            if (wait_dec == '0 && driven_reg != target_cur)
                            begin
                                driven_next    = (target_cur > driven_reg) ?
                                                 driven_reg + 1'b1 : driven_reg - 1'b1;
                                ramp_wait_next = ramp_interval_reg;
                            end
                        end
                        default: ;
                    endcase

                    if (item_in.action == ACT_RPM_QUERY && !stalled)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        out_current_next = driven_next;
                        out_target_next  = target_next;
                        out_rpm_next     = '0;
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    quot_next  = div_quot;
                    state_next = ST_REPLY;
                end
            end

            ST_REPLY:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_current_next = driven_reg;
                    out_target_next  = target_cur;
                    out_rpm_next     = quot_reg;
                    state_next       = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign target_next = (override_next > control_next) ? override_next : control_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            control_reg   <= '0;
            override_reg  <= '0;
            driven_reg    <= '0;
            ramp_wait_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            control_reg   <= control_next;
            override_reg  <= override_next;
            driven_reg    <= driven_next;
            ramp_wait_reg <= ramp_wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_interval_reg <= RAMP_INTERVAL_RST;
            no_spin_reg       <= NO_SPIN_RST;
            rpm_numer_reg     <= RPM_NUMER_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_RAMP_INTERVAL: ramp_interval_reg <= cfg.data[MS_W-1:0];
                REG_NO_SPIN:       no_spin_reg       <= cfg.data[MS_W-1:0];
                REG_RPM_NUMER:     rpm_numer_reg     <= cfg.data[NUMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_current_reg <= out_current_next;
        out_target_reg  <= out_target_next;
        out_rpm_reg     <= out_rpm_next;
        quot_reg        <= quot_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.current_duty = out_current_reg;
    assign result_out.target_duty  = out_target_reg;
    assign result_out.fan_rpm      = out_rpm_reg;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-fan duty ramp and tachometer block.
// A behavioural copy of the controller predicts current duty, target duty and
// fan speed for every accepted command. Each result transaction is compared
// with the oldest prediction. Directed checks, register writes,
// configuration extremes, output back-pressure and random traffic run in turn.
// ----------------------------------------------------------------------------
module tb;
    import fpr_pkg::*;

    localparam int PERIOD_BITS = 16;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};

    // Action codes that the block must ignore.
    localparam action_t ACT_RSVD_FIRST = 3'd5;
    localparam action_t ACT_RSVD_LAST  = 3'd7;
    // Register index with no register behind it.
    localparam cfg_idx_t REG_UNUSED = 2'd3;

    typedef struct packed {
        duty_t cur;
        duty_t tgt;
        rpm_t  rpm;
    } fan_reading_t;

    logic clk = 1'b0;
    logic rst_n;

    fpr_item_if   item_bus ();
    fpr_result_if res_bus ();
    fpr_cfg_if    cfg_bus ();

    fan_pwm_ramp_and_tach_rpm #(
        .PERIOD_BITS (PERIOD_BITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (res_bus),
        .cfg        (cfg_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predicted controller state and register copies.
    ms_t    ramp_ival  = RAMP_INTERVAL_RST;
    ms_t    spin_limit = NO_SPIN_RST;
    numer_t rpm_num    = RPM_NUMER_RST;
    duty_t  ctl_duty   = '0;
    duty_t  ovr_duty   = '0;
    duty_t  drv_duty   = '0;
    ms_t    ramp_left  = '0;
    logic [PERIOD_BITS-1:0] per_run [NUM_FANS] = '{default: '0};
    logic [PERIOD_BITS-1:0] per_lat [NUM_FANS] = '{default: '0};
    ms_t    ms_since [NUM_FANS] = '{default: '0};

    fan_reading_t pending_readings [$];
    int  mismatch_count = 0;
    bit  gaps_on        = 1'b1;
    bit  stalls_on      = 1'b1;
    int  hold_cycles    = 0;

    function automatic duty_t duty_goal();
        return (ovr_duty > ctl_duty) ? ovr_duty : ctl_duty;
    endfunction

    function automatic fan_reading_t predict_fan_item(action_t act, duty_t duty,
                                                      edge_mask_t edges, fan_sel_t fan);
        fan_reading_t r;
        duty_t        goal;
        numer_t       quot;
        r.rpm = '0;
        case (act)
            ACT_SET_CONTROL:  ctl_duty = duty;
            ACT_SET_OVERRIDE: ovr_duty = duty;
            ACT_MS_TICK:
            begin
                goal = duty_goal();
                if (ramp_left != '0)
                    ramp_left = ramp_left - 1'b1;
                if (ramp_left == '0 && drv_duty != goal)
                begin
                    drv_duty  = (goal > drv_duty) ? drv_duty + 1'b1 : drv_duty - 1'b1;
                    ramp_left = ramp_ival;
                end
                for (int i = 0; i < NUM_FANS; i++)
                    if (ms_since[i] != MS_SAT)
                        ms_since[i] = ms_since[i] + 1'b1;
            end
            ACT_REF_TICK:
            begin
                // The tick that carries an edge is not itself counted.
                for (int i = 0; i < NUM_FANS; i++)
                begin
                    if (edges[i])
                    begin
                        per_lat[i]  = per_run[i];
                        per_run[i]  = '0;
                        ms_since[i] = '0;
                    end
                    else if (per_run[i] != PERIOD_MAX)
                        per_run[i] = per_run[i] + 1'b1;
                end
            end
            ACT_RPM_QUERY:
            begin
                if (per_lat[fan] != '0 && ms_since[fan] <= spin_limit)
                begin
                    quot  = rpm_num / per_lat[fan];
                    r.rpm = (quot > RPM_SAT) ? RPM_SAT : quot[RPM_W-1:0];
                end
            end
            default: ;
        endcase
        r.cur = drv_duty;
        r.tgt = duty_goal();
        return r;
    endfunction

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    task automatic send_item(action_t act, duty_t duty, edge_mask_t edges, fan_sel_t fan);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.action     <= act;
        item_bus.duty_value <= duty;
        item_bus.edge_mask  <= edges;
        item_bus.fan_select <= fan;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        pending_readings.push_back(predict_fan_item(act, duty, edges, fan));
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            REG_RAMP_INTERVAL: ramp_ival  = value[MS_W-1:0];
            REG_NO_SPIN:       spin_limit = value[MS_W-1:0];
            REG_RPM_NUMER:     rpm_num    = value;
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop the command channel and wait until every result has come back.
    task automatic settle_idle();
        item_bus.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_random(int count, int edge_odds);
        int         r;
        action_t    act;
        edge_mask_t edges;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)
                act = ACT_REF_TICK;
            else if (r < 62)
                act = ACT_MS_TICK;
            else if (r < 82)
                act = ACT_RPM_QUERY;
            else if (r < 89)
                act = ACT_SET_CONTROL;
            else if (r < 96)
                act = ACT_SET_OVERRIDE;
            else
                act = action_t'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
            edges = {($urandom_range(1, edge_odds) == 1), ($urandom_range(1, edge_odds) == 1)};
            send_item(act, duty_t'($urandom_range(0, 255)), edges,
                      fan_sel_t'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_directed_basics();
        // Both periods are still zero, so both fans read as stopped.
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b1);
        for (int a = ACT_RSVD_FIRST; a <= ACT_RSVD_LAST; a++)
            send_item(action_t'(a), 8'hff, 2'b11, 1'b1);
        send_item(ACT_SET_CONTROL, 8'hff, 2'b00, 1'b0);
        send_item(ACT_SET_OVERRIDE, 8'h00, 2'b00, 1'b0);
        send_item(ACT_MS_TICK, 8'h00, 2'b00, 1'b0);
        send_item(ACT_MS_TICK, 8'h00, 2'b00, 1'b0);
        send_item(ACT_SET_CONTROL, 8'h00, 2'b00, 1'b0);
        send_item(ACT_SET_OVERRIDE, 8'h80, 2'b00, 1'b0);
        send_item(ACT_REF_TICK, 8'h00, 2'b00, 1'b0);
        send_item(ACT_REF_TICK, 8'h00, 2'b00, 1'b0);
        send_item(ACT_REF_TICK, 8'h00, 2'b00, 1'b0);
        send_item(ACT_REF_TICK, 8'h00, 2'b01, 1'b0);
        send_item(ACT_REF_TICK, 8'h00, 2'b10, 1'b0);
        send_item(ACT_REF_TICK, 8'h00, 2'b11, 1'b0);
        send_item(ACT_RPM_QUERY, 8'h00, 2'b00, 1'b0);
        send_item(ACT_RPM_QUERY, 8'h00, 2'b00, 1'b1);
        settle_idle();
    endtask

    task automatic test_register_writes();
        write_reg(REG_UNUSED, 32'hffff_ffff);
        write_reg(REG_RAMP_INTERVAL, 32'd0);
        write_reg(REG_NO_SPIN, 32'd0);
        write_reg(REG_RPM_NUMER, 32'hffff_ffff);
        // With a zero interval the duty steps on every tick.
        send_item(ACT_SET_CONTROL, 8'd200, 2'b00, 1'b0);
        send_item(ACT_MS_TICK, 8'd0, 2'b00, 1'b0);
        send_item(ACT_MS_TICK, 8'd0, 2'b00, 1'b0);
        send_item(ACT_MS_TICK, 8'd0, 2'b00, 1'b0);
        send_item(ACT_REF_TICK, 8'd0, 2'b11, 1'b0);
        send_item(ACT_REF_TICK, 8'd0, 2'b00, 1'b0);
        send_item(ACT_REF_TICK, 8'd0, 2'b11, 1'b0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b0);
        send_item(ACT_MS_TICK, 8'd0, 2'b00, 1'b0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b1);
        settle_idle();
        write_reg(REG_RPM_NUMER, 32'd1);
        send_item(ACT_REF_TICK, 8'd0, 2'b01, 1'b0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b0);
        settle_idle();
    endtask

    // Widest timeout and ramp interval, with a numerator whose rpm saturates.
    task automatic test_config_extremes();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        write_reg(REG_NO_SPIN, 32'hffff);
        write_reg(REG_RAMP_INTERVAL, 32'hffff);
        write_reg(REG_RPM_NUMER, 32'd6553500);
        send_item(ACT_REF_TICK, 8'd0, 2'b11, 1'b0);
        for (int n = 0; n < 40; n++)
            send_item(ACT_REF_TICK, 8'd0, 2'b00, 1'b0);
        send_item(ACT_REF_TICK, 8'd0, 2'b11, 1'b0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b1);
        send_item(ACT_SET_OVERRIDE, 8'd0, 2'b00, 1'b0);
        send_item(ACT_SET_CONTROL, ~drv_duty, 2'b00, 1'b0);
        // The longest interval lets at most one step through here.
        for (int n = 0; n < 40; n++)
            send_item(ACT_MS_TICK, 8'd0, 2'b00, 1'b0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b1);
        settle_idle();
        // With a zero timeout both fans read as stopped once time has passed.
        write_reg(REG_NO_SPIN, 32'd0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b0);
        send_item(ACT_RPM_QUERY, 8'd0, 2'b00, 1'b1);
        settle_idle();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_RAMP_INTERVAL, 32'd1);
        write_reg(REG_NO_SPIN, 32'd50);
        write_reg(REG_RPM_NUMER, RPM_NUMER_RST);
        gaps_on     = 1'b0;
        stalls_on   = 1'b0;
        hold_cycles = 300;
        run_random(40, 5);
        settle_idle();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        cfg_data_t ramp_val;
        cfg_data_t spin_val;
        cfg_data_t numer_val;
        int        odds;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin ramp_val = 1; spin_val = 20; numer_val = RPM_NUMER_RST; odds = 10; end
                1: begin ramp_val = 0; spin_val = 32'hffff; numer_val = 32'hffff_ffff; odds = 6; end
                2: begin ramp_val = 32'hffff; spin_val = 1; numer_val = 1; odds = 3; end
                3:
                begin
                    ramp_val  = $urandom_range(2, 6);
                    spin_val  = 0;
                    numer_val = $urandom;
                    odds      = 12;
                end
                4:
                begin
                    ramp_val  = $urandom_range(1, 16);
                    spin_val  = $urandom_range(2, 50);
                    numer_val = $urandom;
                    odds      = 40;
                end
                default:
                begin
                    ramp_val  = 2;
                    spin_val  = 30;
                    numer_val = $urandom_range(100000, 3000000);
                    odds      = 20;
                end
            endcase
            write_reg(REG_RAMP_INTERVAL, ramp_val);
            write_reg(REG_NO_SPIN, spin_val);
            write_reg(REG_RPM_NUMER, numer_val);
            run_random(280, odds);
            settle_idle();
        end
    endtask

    // Result ready: random stalls, held high while stalls are off, or one long hold-off when asked for.
    initial
    begin : result_ready_drive
        int n;
        forever
        begin
            if (hold_cycles > 0)
            begin
                res_bus.ready <= 1'b0;
                n = hold_cycles;
                hold_cycles = 0;
                repeat (n) @(posedge clk);
            end
            else if (!stalls_on)
            begin
                res_bus.ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 65)
            begin
                res_bus.ready <= 1'b1;
                n = ($urandom_range(0, 99) < 10) ? $urandom_range(30, 80) : $urandom_range(1, 12);
                repeat (n) @(posedge clk);
            end
            else
            begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 1) + pick_gap()) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        fan_reading_t want;
        fan_reading_t got;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got = '{res_bus.current_duty, res_bus.target_duty, res_bus.fan_rpm};
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result transaction with nothing expected: cur %0d tgt %0d rpm %0d",
                             $realtime, got.cur, got.tgt, got.rpm);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch cur %0d/%0d tgt %0d/%0d rpm %0d/%0d (got/expected)",
                                 $realtime, got.cur, want.cur, got.tgt, want.tgt,
                                 got.rpm, want.rpm);
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        item_bus.valid      <= 1'b0;
        item_bus.action     <= ACT_SET_CONTROL;
        item_bus.duty_value <= '0;
        item_bus.edge_mask  <= '0;
        item_bus.fan_select <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= REG_RAMP_INTERVAL;
        cfg_bus.data        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_basics();
        test_register_writes();
        test_config_extremes();
        test_output_backpressure();
        test_random_traffic();

        settle_idle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
